[sv/muart_pkg.sv]
// Shared types and constants for the multichannel oversampled UART core.
// Used by the core and its testbench; depends on nothing.
`timescale 1ns / 1ps

package muart_pkg;

    localparam int CHANNELS      = 4;
    localparam int CH_W          = 2;
    localparam int TX_RING_DEPTH = 64;
    localparam int PTR_W         = 6;
    localparam int LINE_DEPTH    = 64;
    localparam int LEN_W         = 7;
    localparam int RING_AW       = CH_W + PTR_W;
    localparam int PIN_CH        = 4;

    localparam logic [3:0] FRAME_BITS = 4'd9;
    localparam logic [7:0] TPB_RESET  = 8'd3;
    localparam logic [7:0] CHAR_SP    = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam logic [1:0] K_TICK    = 2'd0;
    localparam logic [1:0] K_ENQ     = 2'd1;
    localparam logic [1:0] K_RELEASE = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] channel;
        logic [7:0] tx_byte;
        logic [3:0] rx_lines;
    } t_in_item;

    typedef struct packed {
        logic [3:0] tx_lines;
        logic       rx_event;
        logic [1:0] rx_channel;
        logic [7:0] rx_byte;
        logic       rx_stored;
        logic       line_ready;
        logic       tx_dropped;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic             rx_busy;
        logic [7:0]       rx_cnt;
        logic [3:0]       rx_bits;
        logic [7:0]       rx_shift;
        logic             tx_busy;
        logic [7:0]       tx_cnt;
        logic [3:0]       tx_bits;
        logic [7:0]       tx_shift;
        logic [7:0]       tx_hold;
        logic [PTR_W-1:0] rd_ptr;
        logic [PTR_W-1:0] wr_ptr;
        logic [LEN_W-1:0] line_len;
        logic             line_flag;
    } t_chan_state;

endpackage

[sv/multichannel_oversampled_uart_core.sv]
// Top level of the multichannel oversampled UART core: sequencer, per-channel
// state memory and transmit ring memory. Depends on muart_pkg and muart_ram.
//
//   channel   direction   handshake                 payload
//   in        input       i_in_valid / o_in_stall   i_in_item  (t_in_item)
//   out       output      o_out_valid / i_out_stall o_out_item (t_out_item)
//   cfg       input       i_cfg_wr_en               i_cfg_wr_data (ticks_per_bit)
//
// A tick walks every channel through state read, ring read and write back, then
// emits one result per channel that received a byte, or a single result when none
// did. Enqueue and release pass through state read, ring read, write back and finish;
// an unknown kind goes straight to finish.
// Reset is synchronous; per-entry valid bits make the state memory read as zero.
// Output stall holds the result register; a new item is taken once the
// sequencer is idle, while a result may still wait.
`timescale 1ns / 1ps

module multichannel_oversampled_uart_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  muart_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output muart_pkg::t_out_item  o_out_item,
    input  logic                  i_cfg_wr_en,
    input  logic [7:0]            i_cfg_wr_data
);
    import muart_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_RING, S_WR, S_EMIT, S_FIN
    } t_state;

    localparam int SW = $bits(t_chan_state);

    t_state              r_state;
    t_in_item            r_in;
    logic [CH_W-1:0]     r_ch;
    logic [CH_W-1:0]     r_ech;
    logic [7:0]          r_tpb;
    logic [CHANNELS-1:0] r_vld;
    logic [CHANNELS-1:0] r_lvl;
    logic [CHANNELS-1:0] r_got;
    logic [CHANNELS-1:0] r_sto;
    logic [CHANNELS-1:0] r_flag;
    logic [7:0]          r_val [CHANNELS];
    logic                r_drop;

    logic [SW-1:0]       state_q;
    logic [7:0]          ring_q;
    t_chan_state         st;
    t_chan_state         n_st;
    logic                st_we;
    logic                ring_we;
    logic                got;
    logic                sto;
    logic                lvl;
    logic                drop;
    logic                rx_level;
    logic [7:0]          cnt_dn;
    logic [3:0]          bits_dn;
    logic [LEN_W-1:0]    len_inc;
    logic                out_free;
    logic                later;
    logic                emit;

    assign st       = r_vld[r_ch] ? t_chan_state'(state_q) : '0;
    assign out_free = !o_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign rx_level = r_in.rx_lines[r_ch];
    assign emit     = out_free && (r_state == S_FIN
                      || (r_state == S_EMIT && (r_got == '0 || r_got[r_ech])));

    muart_ram #(.WIDTH(SW), .DEPTH(CHANNELS)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_ch),
        .i_wdata (SW'(n_st)),
        .i_re    (r_state == S_RD),
        .i_raddr (r_ch),
        .o_rdata (state_q)
    );

    muart_ram #(.WIDTH(8), .DEPTH(CHANNELS * TX_RING_DEPTH)) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr ({r_ch, st.wr_ptr}),
        .i_wdata (r_in.tx_byte),
        .i_re    (r_state == S_RING),
        .i_raddr ({r_ch, st.rd_ptr}),
        .o_rdata (ring_q)
    );

    always_comb begin
        n_st    = st;
        got     = 1'b0;
        sto     = 1'b0;
        lvl     = r_lvl[r_ch];
        drop    = 1'b0;
        ring_we = 1'b0;
        cnt_dn  = '0;
        bits_dn = '0;
        len_inc = st.line_len + LEN_W'(1);
        case (r_in.kind)
            K_TICK: begin
                if (st.rx_busy) begin
                    cnt_dn = (st.rx_cnt != 8'd0) ? st.rx_cnt - 8'd1 : 8'd0;
                    if (cnt_dn == 8'd0) begin
                        n_st.rx_cnt = r_tpb;
                        bits_dn = (st.rx_bits != 4'd0) ? st.rx_bits - 4'd1 : 4'd0;
                        n_st.rx_bits = bits_dn;
                        if (bits_dn == 4'd0) begin
                            n_st.rx_busy = 1'b0;
                            got = 1'b1;
                            if (!(st.line_len == '0 && (st.rx_shift == CHAR_SP
                                    || st.rx_shift == CHAR_CR || st.rx_shift == CHAR_LF))
                                    && st.line_len < LEN_W'(LINE_DEPTH)) begin
                                sto = 1'b1;
                                n_st.line_len = len_inc;
                                if (len_inc >= LEN_W'(LINE_DEPTH) || st.rx_shift == CHAR_LF) begin
                                    n_st.line_flag = 1'b1;
                                end
                            end
                        end else begin
                            n_st.rx_shift = {rx_level, st.rx_shift[7:1]};
                        end
                    end else begin
                        n_st.rx_cnt = cnt_dn;
                    end
                end else if (!rx_level) begin
                    n_st.rx_busy  = 1'b1;
                    n_st.rx_cnt   = (r_tpb == 8'hFF) ? 8'hFF : r_tpb + 8'd1;
                    n_st.rx_bits  = FRAME_BITS;
                    n_st.rx_shift = '0;
                end
                if (!st.tx_busy && st.rd_ptr != st.wr_ptr) begin
                    n_st.tx_hold = ring_q;
                    n_st.rd_ptr  = (st.rd_ptr == PTR_W'(TX_RING_DEPTH - 1))
                                   ? '0 : st.rd_ptr + PTR_W'(1);
                    n_st.tx_busy = 1'b1;
                end
                if (n_st.tx_busy) begin
                    cnt_dn = (st.tx_cnt != 8'd0) ? st.tx_cnt - 8'd1 : 8'd0;
                    if (cnt_dn == 8'd0) begin
                        n_st.tx_cnt = r_tpb;
                        if (st.tx_bits == 4'd0) begin
                            lvl = 1'b0;
                            n_st.tx_shift = n_st.tx_hold;
                            n_st.tx_bits  = FRAME_BITS;
                        end else begin
                            n_st.tx_bits = st.tx_bits - 4'd1;
                            if (n_st.tx_bits == 4'd0) begin
                                lvl = 1'b1;
                                n_st.tx_busy = 1'b0;
                            end else begin
                                lvl = st.tx_shift[0];
                                n_st.tx_shift = {1'b0, st.tx_shift[7:1]};
                            end
                        end
                    end else begin
                        n_st.tx_cnt = cnt_dn;
                    end
                end
            end
            K_ENQ: begin
                n_st.wr_ptr = (st.wr_ptr == PTR_W'(TX_RING_DEPTH - 1))
                              ? '0 : st.wr_ptr + PTR_W'(1);
                if (n_st.wr_ptr == st.rd_ptr) begin
                    drop = 1'b1;
                    n_st.wr_ptr = st.wr_ptr;
                end else begin
                    ring_we = (r_state == S_WR);
                end
            end
            K_RELEASE: begin
                n_st.line_len  = '0;
                n_st.line_flag = 1'b0;
            end
            default: begin
                drop = 1'b0;
            end
        endcase
        st_we = (r_state == S_WR);
    end

    always_comb begin
        later = 1'b0;
        for (int k = 0; k < CHANNELS; k++) begin
            if (k > int'(r_ech) && r_got[k]) begin
                later = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tpb       <= TPB_RESET;
            r_vld       <= '0;
            r_lvl       <= '1;
            r_got       <= '0;
            r_ch        <= '0;
            r_ech       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tpb <= i_cfg_wr_data;
            end
            if (o_out_valid && !i_out_stall && !emit) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in   <= i_in_item;
                        r_got  <= '0;
                        r_drop <= 1'b0;
                        r_ch   <= (i_in_item.kind == K_TICK) ? '0 : i_in_item.channel;
                        if (i_in_item.kind == K_TICK || i_in_item.kind == K_ENQ
                                || i_in_item.kind == K_RELEASE) begin
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_RING;
                end
                S_RING: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_vld[r_ch] <= 1'b1;
                    if (r_in.kind == K_TICK) begin
                        r_lvl[r_ch]  <= lvl;
                        r_got[r_ch]  <= got;
                        r_sto[r_ch]  <= sto;
                        r_flag[r_ch] <= n_st.line_flag;
                        r_val[r_ch]  <= st.rx_shift;
                        if (r_ch == CH_W'(CHANNELS - 1)) begin
                            r_ech   <= '0;
                            r_state <= S_EMIT;
                        end else begin
                            r_ch    <= r_ch + CH_W'(1);
                            r_state <= S_RD;
                        end
                    end else begin
                        r_drop  <= drop;
                        r_state <= S_FIN;
                    end
                end
                S_EMIT: begin
                    if (r_got == '0) begin
                        if (out_free) begin
                            o_out_valid <= 1'b1;
                            o_out_item  <= '{tx_lines: r_lvl[PIN_CH-1:0], last: 1'b1,
                                             default: '0};
                            r_state     <= S_IDLE;
                        end
                    end else if (r_got[r_ech]) begin
                        if (out_free) begin
                            o_out_valid <= 1'b1;
                            o_out_item  <= '{tx_lines: r_lvl[PIN_CH-1:0], rx_event: 1'b1,
                                             rx_channel: r_ech, rx_byte: r_val[r_ech],
                                             rx_stored: r_sto[r_ech],
                                             line_ready: r_flag[r_ech],
                                             tx_dropped: 1'b0, last: !later};
                            r_ech       <= r_ech + CH_W'(1);
                            if (!later) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end else begin
                        r_ech <= r_ech + CH_W'(1);
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        o_out_valid <= 1'b1;
                        o_out_item  <= '{tx_lines: r_lvl[PIN_CH-1:0], tx_dropped: r_drop,
                                         last: 1'b1, default: '0};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_state != S_IDLE)
        else $error("accepted item did not start the sequencer");

    a_tick_walks_channels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WR && r_in.kind == K_TICK |=> r_state == S_RD || r_state == S_EMIT)
        else $error("tick sequence left the channel walk");

    a_fin_loads_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN && out_free |=> o_out_valid && o_out_item.last)
        else $error("single result not marked last");

endmodule

[sv/muart_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module muart_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[sim/multichannel_oversampled_uart_core_tb.sv]
// Testbench for the multichannel oversampled UART core: drives ticks, enqueues and
// releases, predicts every result and compares it field by field. Depends on muart_pkg.
`timescale 1ns / 1ps

module multichannel_oversampled_uart_core_tb;
    import muart_pkg::*;

    localparam logic [1:0] K_UNKNOWN = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;
    logic      i_cfg_wr_en;
    logic [7:0] i_cfg_wr_data;

    multichannel_oversampled_uart_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data)
    );

    // predictor state
    logic [7:0] m_tpb;
    logic       m_rx_busy [CHANNELS];
    logic [7:0] m_rx_cnt [CHANNELS];
    logic [3:0] m_rx_bits [CHANNELS];
    logic [7:0] m_rx_shift [CHANNELS];
    logic       m_tx_busy [CHANNELS];
    logic [7:0] m_tx_cnt [CHANNELS];
    logic [3:0] m_tx_bits [CHANNELS];
    logic [7:0] m_tx_shift [CHANNELS];
    logic [7:0] m_tx_hold [CHANNELS];
    logic       m_tx_level [CHANNELS];
    logic [7:0] m_ring [CHANNELS][TX_RING_DEPTH];
    int         m_rd [CHANNELS];
    int         m_wr [CHANNELS];
    int         m_len [CHANNELS];
    logic       m_flag [CHANNELS];

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  rx_bytes_seen = 0;
    int  drops_seen = 0;
    int  lines_seen = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_cycles = 0;
    int  quiet_cycles = 0;
    bit  done = 0;

    function automatic logic [3:0] tx_pins();
        logic [3:0] v;
        v = '0;
        for (int c = 0; c < CHANNELS && c < 4; c++) v[c] = m_tx_level[c];
        return v;
    endfunction

    function automatic t_out_item make_result(logic ev, logic [1:0] ch, logic [7:0] by,
                                              logic st, logic rdy, logic drop);
        t_out_item r;
        r.tx_lines = tx_pins();
        r.rx_event = ev;
        r.rx_channel = ch;
        r.rx_byte = by;
        r.rx_stored = st;
        r.line_ready = rdy;
        r.tx_dropped = drop;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic reset_predictor();
        m_tpb = TPB_RESET;
        for (int c = 0; c < CHANNELS; c++) begin
            m_rx_busy[c] = 0; m_rx_cnt[c] = 0; m_rx_bits[c] = 0; m_rx_shift[c] = 0;
            m_tx_busy[c] = 0; m_tx_cnt[c] = 0; m_tx_bits[c] = 0; m_tx_shift[c] = 0;
            m_tx_hold[c] = 0; m_tx_level[c] = 1; m_rd[c] = 0; m_wr[c] = 0;
            m_len[c] = 0; m_flag[c] = 0;
        end
    endtask

    function automatic logic store_byte(int c, logic [7:0] b);
        if (m_len[c] == 0 && (b == CHAR_SP || b == CHAR_CR || b == CHAR_LF)) return 0;
        if (m_len[c] >= LINE_DEPTH) return 0;
        m_len[c]++;
        if (m_len[c] >= LINE_DEPTH || b == CHAR_LF) m_flag[c] = 1;
        return 1;
    endfunction

    function automatic logic step_down(ref logic [7:0] cnt);
        if (cnt > 0) cnt--;
        return cnt == 0;
    endfunction

    task automatic predict_uart(t_in_item it);
        t_out_item res[$];
        logic got [CHANNELS];
        logic [7:0] val [CHANNELS];
        logic sto [CHANNELS];
        logic drop;
        logic level;
        int c;
        int nw;
        if (it.kind == K_ENQ) begin
            drop = 1;
            c = it.channel;
            nw = (m_wr[c] + 1) % TX_RING_DEPTH;
            if (nw != m_rd[c]) begin
                m_ring[c][m_wr[c]] = it.tx_byte;
                m_wr[c] = nw;
                drop = 0;
            end
            res.push_back(make_result(0, 0, 0, 0, 0, drop));
        end else if (it.kind == K_RELEASE) begin
            m_len[it.channel] = 0;
            m_flag[it.channel] = 0;
            res.push_back(make_result(0, 0, 0, 0, 0, 0));
        end else if (it.kind == K_UNKNOWN) begin
            res.push_back(make_result(0, 0, 0, 0, 0, 0));
        end else begin
            for (c = 0; c < CHANNELS; c++) begin
                level = it.rx_lines[c];
                got[c] = 0; val[c] = 0; sto[c] = 0;
                if (m_rx_busy[c]) begin
                    if (step_down(m_rx_cnt[c])) begin
                        m_rx_cnt[c] = m_tpb;
                        if (m_rx_bits[c] > 0) m_rx_bits[c]--;
                        if (m_rx_bits[c] == 0) begin
                            m_rx_busy[c] = 0;
                            got[c] = 1;
                            val[c] = m_rx_shift[c];
                            sto[c] = store_byte(c, m_rx_shift[c]);
                        end else begin
                            m_rx_shift[c] = {level, m_rx_shift[c][7:1]};
                        end
                    end
                end else if (!level) begin
                    m_rx_busy[c] = 1;
                    m_rx_cnt[c] = (m_tpb == 8'd255) ? 8'd255 : m_tpb + 8'd1;
                    m_rx_bits[c] = FRAME_BITS;
                    m_rx_shift[c] = 0;
                end
            end
            for (c = 0; c < CHANNELS; c++) begin
                if (!m_tx_busy[c] && m_rd[c] != m_wr[c]) begin
                    m_tx_hold[c] = m_ring[c][m_rd[c]];
                    m_rd[c] = (m_rd[c] + 1) % TX_RING_DEPTH;
                    m_tx_busy[c] = 1;
                end
                if (m_tx_busy[c] && step_down(m_tx_cnt[c])) begin
                    m_tx_cnt[c] = m_tpb;
                    if (m_tx_bits[c] == 0) begin
                        m_tx_level[c] = 0;
                        m_tx_shift[c] = m_tx_hold[c];
                        m_tx_bits[c] = FRAME_BITS;
                    end else begin
                        m_tx_bits[c]--;
                        if (m_tx_bits[c] == 0) begin
                            m_tx_level[c] = 1;
                            m_tx_busy[c] = 0;
                        end else begin
                            m_tx_level[c] = m_tx_shift[c][0];
                            m_tx_shift[c] = m_tx_shift[c] >> 1;
                        end
                    end
                end
            end
            for (c = 0; c < CHANNELS; c++)
                if (got[c])
                    res.push_back(make_result(1, 2'(c), val[c], sto[c], m_flag[c], 0));
            if (res.size() == 0) res.push_back(make_result(0, 0, 0, 0, 0, 0));
        end
        res[res.size() - 1].last = 1'b1;
        foreach (res[i]) expected_results.push_back(res[i]);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("MISMATCH result %0d %s: got %0h expected %0h", results_seen, what, got, want);
    endtask

    // clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 0;
        end else if (i_in_valid && !o_in_stall) begin
            predict_uart(i_in_item);
            void'(pending_items.pop_front());
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1;
                i_in_item <= pending_items[0];
            end else begin
                i_in_valid <= 0;
            end
        end else if (!i_in_valid && pending_items.size() > 0
                     && $urandom_range(99) >= send_idle_pct) begin
            i_in_valid <= 1;
            i_in_item <= pending_items[0];
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_out_item.tx_lines !== want.tx_lines)
                    report_mismatch("tx_lines", o_out_item.tx_lines, want.tx_lines);
                if (o_out_item.rx_event !== want.rx_event)
                    report_mismatch("rx_event", o_out_item.rx_event, want.rx_event);
                if (o_out_item.rx_channel !== want.rx_channel)
                    report_mismatch("rx_channel", o_out_item.rx_channel, want.rx_channel);
                if (o_out_item.rx_byte !== want.rx_byte)
                    report_mismatch("rx_byte", o_out_item.rx_byte, want.rx_byte);
                if (o_out_item.rx_stored !== want.rx_stored)
                    report_mismatch("rx_stored", o_out_item.rx_stored, want.rx_stored);
                if (o_out_item.line_ready !== want.line_ready)
                    report_mismatch("line_ready", o_out_item.line_ready, want.line_ready);
                if (o_out_item.tx_dropped !== want.tx_dropped)
                    report_mismatch("tx_dropped", o_out_item.tx_dropped, want.tx_dropped);
                if (o_out_item.last !== want.last)
                    report_mismatch("last", o_out_item.last, want.last);
                if (want.rx_event) rx_bytes_seen++;
                if (want.tx_dropped) drops_seen++;
                if (want.line_ready) lines_seen++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (!done && quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", expected_results.size());
            $display("multichannel_oversampled_uart_core test failed");
            $finish;
        end
    end

    function automatic t_in_item tick_item(logic [3:0] lines);
        t_in_item it;
        it = '0;
        it.kind = K_TICK;
        it.rx_lines = lines;
        it.tx_byte = 8'($urandom_range(255));
        it.channel = 2'($urandom_range(3));
        return it;
    endfunction

    function automatic t_in_item ctl_item(logic [1:0] kind, logic [1:0] ch, logic [7:0] b);
        t_in_item it;
        it.kind = kind;
        it.channel = ch;
        it.tx_byte = b;
        it.rx_lines = 4'($urandom_range(15));
        return it;
    endfunction

    // Frame one byte per channel onto the receive lines, tpb ticks per bit.
    task automatic push_frames(logic [7:0] bytes [4], logic [3:0] active, int tpb);
        logic [3:0] lines;
        int idle;
        idle = $urandom_range(2);
        for (int t = 0; t < idle; t++) pending_items.push_back(tick_item(4'hF));
        for (int bit_i = 0; bit_i < 10; bit_i++) begin
            for (int c = 0; c < 4; c++) begin
                if (!active[c]) lines[c] = 1'b1;
                else if (bit_i == 0) lines[c] = 1'b0;
                else if (bit_i == 9) lines[c] = 1'b1;
                else lines[c] = bytes[c][bit_i - 1];
            end
            for (int t = 0; t < tpb; t++) begin
                pending_items.push_back(tick_item(lines));
                if ($urandom_range(15) == 0)
                    pending_items.push_back(ctl_item(K_ENQ, 2'($urandom_range(3)),
                                                     8'($urandom_range(255))));
            end
        end
    endtask

    task automatic wait_drained(int settle);
        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_tpb(logic [7:0] v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        m_tpb = v;
    endtask

    task automatic random_phase(int count, int tpb);
        logic [7:0] bytes [4];
        int r;
        int start;
        start = pending_items.size();
        while (pending_items.size() - start < count) begin
            r = $urandom_range(99);
            if (r < 55) begin
                for (int c = 0; c < 4; c++) begin
                    case ($urandom_range(5))
                        0: bytes[c] = CHAR_LF;
                        1: bytes[c] = CHAR_SP;
                        2: bytes[c] = CHAR_CR;
                        default: bytes[c] = 8'($urandom_range(255));
                    endcase
                end
                push_frames(bytes, 4'($urandom_range(15)), tpb);
            end else if (r < 75) begin
                pending_items.push_back(ctl_item(K_ENQ, 2'($urandom_range(3)),
                                                 8'($urandom_range(255))));
            end else if (r < 85) begin
                pending_items.push_back(ctl_item(K_RELEASE, 2'($urandom_range(3)),
                                                 8'($urandom_range(255))));
            end else if (r < 88) begin
                pending_items.push_back(ctl_item(K_UNKNOWN, 2'($urandom_range(3)),
                                                 8'($urandom_range(255))));
            end else begin
                pending_items.push_back(tick_item(4'($urandom_range(15))));
            end
        end
    endtask

    initial begin
        logic [7:0] bytes [4];
        t_in_item it;
        reset_predictor();
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_item = '0;
        i_out_stall = 0;
        i_cfg_wr_en = 0;
        i_cfg_wr_data = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        send_idle_pct = 33;
        recv_idle_pct = 63;

        // directed: extremes, every kind, skipped leading characters
        bytes = '{8'h00, 8'hFF, CHAR_SP, 8'hA5};
        push_frames(bytes, 4'hF, 3);
        pending_items.push_back(ctl_item(K_ENQ, 2'd0, 8'h00));
        pending_items.push_back(ctl_item(K_ENQ, 2'd3, 8'hFF));
        pending_items.push_back(ctl_item(K_UNKNOWN, 2'd3, 8'hFF));
        pending_items.push_back(ctl_item(K_RELEASE, 2'd1, 8'h00));
        for (int t = 0; t < 5; t++) pending_items.push_back(tick_item(4'hF));
        bytes = '{CHAR_CR, CHAR_LF, 8'h41, CHAR_LF};
        push_frames(bytes, 4'hF, 3);
        wait_drained(30);

        // full ring on channel 2 with the receiver held off for a long stretch
        write_tpb(8'd255);
        hold_cycles <= 600;
        for (int i = 0; i < 66; i++)
            pending_items.push_back(ctl_item(K_ENQ, 2'd2, 8'($urandom_range(255))));
        for (int i = 0; i < 20; i++) pending_items.push_back(tick_item(4'hF));
        pending_items.push_back(tick_item(4'h0));
        wait_drained(30);

        // ring drains slowly at 255; move to the smallest ticks_per_bit setting of the test
        write_tpb(8'd2);
        for (int i = 0; i < 3; i++)
            pending_items.push_back(ctl_item(K_RELEASE, 2'(i), 8'h00));
        random_phase(100, 2);
        wait_drained(30);

        send_idle_pct = 63;
        recv_idle_pct = 33;
        write_tpb(8'd4);
        // printable bytes on channel 0 only
        for (int i = 0; i < 3; i++) begin
            bytes = '{8'($urandom_range(8'h21, 8'h7E)), 8'h30, 8'h31, 8'h32};
            push_frames(bytes, 4'h1, 4);
        end
        random_phase(30, 4);
        wait_drained(30);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_tpb(8'd3);
        random_phase(40, 3);
        wait_drained(60);
        done = 1;

        $display("covered %0d results, %0d received bytes, %0d dropped enqueues, %0d ready lines",
                 results_seen, rx_bytes_seen, drops_seen, lines_seen);
        $display("ticks_per_bit settings 3, 255, 2, 4; long output hold with full input");
        if (mismatches == 0) begin
            $display("multichannel_oversampled_uart_core test passed");
        end else begin
            $display("multichannel_oversampled_uart_core test failed");
        end
        $finish;
    end
endmodule
